[src/accessory_link_control_top_macros.svh]
// assertion macros used by the accessory link control rtl
`ifndef ACCESSORY_LINK_CONTROL_TOP_MACROS_SVH
`define ACCESSORY_LINK_CONTROL_TOP_MACROS_SVH

// property checked at every edge outside reset
`define ALC_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// consequence checked at the edge after the antecedent
`define ALC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

[src/alc_pkg.sv]
// types, constants and codes of the accessory link control block
`timescale 1ns / 1ps
package alc_pkg;

   localparam int ProfileCount  = 8;
   localparam int LinkProfileId = 1;
   localparam int BaudCount     = 12;

   localparam int CsrAddrWidth  = 5;
   localparam int CsrDataWidth  = 32;

   typedef enum logic [2:0] {
      OP_FRAME      = 3'd0,
      OP_TICK       = 3'd1,
      OP_SEND_FAIL  = 3'd2,
      OP_DISCONNECT = 3'd3,
      OP_READ_ABORT = 3'd4
   } op_type;

   localparam logic [1:0] LINK_TYPE_NONE     = 2'd0;
   localparam logic [1:0] LINK_TYPE_STATUS   = 2'd1;
   localparam logic [1:0] LINK_TYPE_PROFILES = 2'd2;
   localparam logic [1:0] LINK_TYPE_BAUD     = 2'd3;

   localparam logic [7:0] STATUS_OK         = 8'd0;
   localparam logic [7:0] STATUS_BAUD       = 8'd1;
   localparam logic [7:0] STATUS_DISCONNECT = 8'd2;

   localparam logic [2:0] REG_STRIKE_LIMIT  = 3'd0;
   localparam logic [2:0] REG_STATUS_CHECK  = 3'd1;
   localparam logic [2:0] REG_CONNECT_GAP   = 3'd2;
   localparam logic [2:0] REG_STATUS_GAP    = 3'd3;
   localparam logic [2:0] REG_PROTOCOL_VER  = 3'd4;

   localparam logic [2:0] STRIKE_MAX = 3'd7;

   typedef struct packed {
      logic [2:0] strike_limit;
      logic [7:0] status_check_seconds;
      logic [7:0] connect_gap_seconds;
      logic [7:0] status_gap_seconds;
      logic [7:0] protocol_version;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      strike_limit:         3'd3,
      status_check_seconds: 8'd5,
      connect_gap_seconds:  8'd1,
      status_gap_seconds:   8'd5,
      protocol_version:     8'd1
   };

   typedef struct packed {
      op_type      op;
      logic        frame_ok;
      logic        type_small;
      logic [1:0]  type_lo;
      logic [7:0]  status_byte;
      logic        len_odd;
      logic        baud_ok;
      logic [31:0] profiles;
      logic        connect_cond;
      logic        status_cond;
      logic [31:0] now_seconds;
      logic        contention;
   } item_type;

   typedef struct packed {
      logic        send_valid;
      logic [1:0]  send_type;
      logic        baud_valid;
      logic [3:0]  baud_index;
      logic        conn_valid;
      logic        conn_value;
      logic        frame_accepted;
      logic        control_active;
      logic [31:0] profile_mask;
   } result_type;

endpackage

[src/alc_channels.sv]
// event and result channel interfaces
`timescale 1ns / 1ps
interface alc_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  op;
   logic        rx_ok;
   logic [7:0]  rx_length;
   logic [7:0]  rx_version;
   logic [7:0]  rx_type;
   logic [31:0] rx_payload;
   logic [31:0] now_seconds;
   logic        link_up;
   logic        accessory_present;
   logic        transport_ready;
   logic [31:0] idle_seconds;
   logic        bus_contention;

   modport source (
      output valid, op, rx_ok, rx_length, rx_version, rx_type, rx_payload, now_seconds,
             link_up, accessory_present, transport_ready, idle_seconds, bus_contention,
      input  ready
   );
   modport sink (
      input  valid, op, rx_ok, rx_length, rx_version, rx_type, rx_payload, now_seconds,
             link_up, accessory_present, transport_ready, idle_seconds, bus_contention,
      output ready
   );
endinterface

interface alc_rsp_if;
   logic        valid;
   logic        ready;
   logic        send_valid;
   logic [1:0]  send_type;
   logic        baud_valid;
   logic [3:0]  baud_index;
   logic        conn_valid;
   logic        conn_value;
   logic        frame_accepted;
   logic        control_active;
   logic [31:0] profile_mask;

   modport source (
      output valid, send_valid, send_type, baud_valid, baud_index, conn_valid, conn_value,
             frame_accepted, control_active, profile_mask,
      input  ready
   );
   modport sink (
      input  valid, send_valid, send_type, baud_valid, baud_index, conn_valid, conn_value,
             frame_accepted, control_active, profile_mask,
      output ready
   );
endinterface

[src/alc_csr.sv]
// apb configuration registers
`timescale 1ns / 1ps
module alc_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [alc_pkg::CsrAddrWidth-1:0]   paddr,
   input  logic [alc_pkg::CsrDataWidth-1:0]   pwdata,
   output logic [alc_pkg::CsrDataWidth-1:0]   prdata,
   output logic                               pready,
   output alc_pkg::cfg_type                   cfg
);
   import alc_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   logic [2:0] reg_sel;
   logic       wr_en;

   assign reg_sel = paddr[CsrAddrWidth-1:2];
   assign wr_en   = psel && penable && pwrite;
   assign pready  = 1'b1;
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_sel)
            REG_STRIKE_LIMIT: cfg_in.strike_limit         = pwdata[2:0];
            REG_STATUS_CHECK: cfg_in.status_check_seconds = pwdata[7:0];
            REG_CONNECT_GAP:  cfg_in.connect_gap_seconds  = pwdata[7:0];
            REG_STATUS_GAP:   cfg_in.status_gap_seconds   = pwdata[7:0];
            REG_PROTOCOL_VER: cfg_in.protocol_version     = pwdata[7:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_STRIKE_LIMIT: prdata = {29'd0, cfg_ff.strike_limit};
         REG_STATUS_CHECK: prdata = {24'd0, cfg_ff.status_check_seconds};
         REG_CONNECT_GAP:  prdata = {24'd0, cfg_ff.connect_gap_seconds};
         REG_STATUS_GAP:   prdata = {24'd0, cfg_ff.status_gap_seconds};
         REG_PROTOCOL_VER: prdata = {24'd0, cfg_ff.protocol_version};
         default:          prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

[src/alc_queue.sv]
// two-word queue between event classification and execution
`timescale 1ns / 1ps
module alc_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  alc_pkg::item_type  push_item,
   output logic               not_full,
   input  logic               pop,
   output logic               out_valid,
   output alc_pkg::item_type  out_item
);
   import alc_pkg::*;

   item_type   slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign not_full  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_item  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

[src/alc_front.sv]
// event intake: checks frame header and payload, decodes tick conditions
`timescale 1ns / 1ps
module alc_front (
   alc_req_if.sink            req_port,
   input  alc_pkg::cfg_type   cfg,
   input  logic               queue_not_full,
   output logic               push,
   output alc_pkg::item_type  push_item
);
   import alc_pkg::*;

   logic        len_ok;
   logic [7:0]  dlen;
   logic [2:0]  dlen_s;
   logic [31:0] pay;
   logic [31:0] profiles;
   logic [15:0] prof_id;

   assign req_port.ready = queue_not_full;
   assign push           = req_port.valid && queue_not_full;

   assign len_ok = (req_port.rx_length >= 8'd2) && (req_port.rx_length <= 8'd6);
   assign dlen   = req_port.rx_length - 8'd2;
   assign dlen_s = dlen[2:0];

   // bytes past the frame end read as zero
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         pay[8*k +: 8] = (dlen_s > 3'(k)) ? req_port.rx_payload[8*k +: 8] : 8'd0;
      end
   end

   always_comb begin
      profiles = '0;
      prof_id  = '0;
      for (int i = 0; i < 2; i++) begin
         prof_id = pay[16*i +: 16];
         if ((dlen_s >= 3'(2*i+2)) && (prof_id != 16'd0) && (prof_id < 16'(ProfileCount))
               && (prof_id != 16'(LinkProfileId)) && (prof_id < 16'd32)) begin
            profiles[prof_id[4:0]] = 1'b1;
         end
      end
   end

   always_comb begin
      push_item.op           = op_type'(req_port.op);
      push_item.frame_ok     = req_port.rx_ok && len_ok
                               && (req_port.rx_version == cfg.protocol_version);
      push_item.type_small   = (req_port.rx_type[7:2] == 6'd0);
      push_item.type_lo      = req_port.rx_type[1:0];
      push_item.status_byte  = pay[7:0];
      push_item.len_odd      = dlen_s[0];
      push_item.baud_ok      = (pay[7:0] < 8'(BaudCount));
      push_item.profiles     = profiles;
      push_item.connect_cond = !req_port.link_up && req_port.accessory_present
                               && req_port.transport_ready;
      push_item.status_cond  = (req_port.idle_seconds > {24'd0, cfg.status_check_seconds});
      push_item.now_seconds  = req_port.now_seconds;
      push_item.contention   = req_port.bus_contention;
   end

endmodule

[src/alc_back.sv]
// event execution: link state, strikes, rate limits and result register
`timescale 1ns / 1ps
module alc_back (
   input  logic               clock,
   input  logic               reset,
   input  alc_pkg::cfg_type   cfg,
   input  logic               q_valid,
   input  alc_pkg::item_type  q_item,
   output logic               pop,
   alc_rsp_if.source          rsp_port
);
   import alc_pkg::*;

   `include "accessory_link_control_top_macros.svh"

   logic [2:0]  strike_ff, strike_in;
   logic [31:0] prof_ff, prof_in;
   logic [1:0]  last_ff, last_in;
   logic        pend_ff, pend_in;
   logic [31:0] lct_ff, lct_in;
   logic [31:0] lst_ff, lst_in;
   logic        rsp_valid_ff, rsp_valid_in;
   result_type  rsp_ff, res;

   logic        reject, do_drop, do_strike, do_send;
   logic [1:0]  send_code;
   logic [2:0]  strike_sat;
   logic        connect_due, status_due;

   assign pop          = q_valid && (!rsp_valid_ff || rsp_port.ready);
   assign rsp_valid_in = pop || (rsp_valid_ff && !rsp_port.ready);

   assign connect_due = ({1'b0, q_item.now_seconds} >
                         ({1'b0, lct_ff} + {25'd0, cfg.connect_gap_seconds}));
   assign status_due  = ({1'b0, q_item.now_seconds} >
                         ({1'b0, lst_ff} + {25'd0, cfg.status_gap_seconds}));
   assign reject = !q_item.frame_ok || !q_item.type_small || (q_item.type_lo != last_ff);

   always_comb begin
      strike_in  = strike_ff;
      prof_in    = prof_ff;
      last_in    = last_ff;
      pend_in    = pend_ff;
      lct_in     = lct_ff;
      lst_in     = lst_ff;
      res        = '0;
      do_drop    = 1'b0;
      do_strike  = 1'b0;
      do_send    = 1'b0;
      send_code  = LINK_TYPE_NONE;
      strike_sat = strike_ff;
      unique case (q_item.op)
         OP_FRAME: begin
            pend_in = 1'b0;
            if (reject) begin
               if (last_ff == LINK_TYPE_STATUS) begin
                  do_strike = 1'b1;
               end else if (prof_ff == '0) begin
                  do_drop = 1'b1;
               end
            end else begin
               strike_in = '0;
               unique case (q_item.type_lo)
                  LINK_TYPE_STATUS: begin
                     unique case (q_item.status_byte)
                        STATUS_OK: begin
                           res.conn_valid     = 1'b1;
                           res.conn_value     = 1'b1;
                           res.frame_accepted = 1'b1;
                        end
                        STATUS_BAUD: begin
                           do_send            = 1'b1;
                           send_code          = LINK_TYPE_BAUD;
                           res.frame_accepted = 1'b1;
                        end
                        STATUS_DISCONNECT: begin
                           do_drop            = 1'b1;
                           res.frame_accepted = 1'b1;
                        end
                        default: do_drop = 1'b1;
                     endcase
                  end
                  LINK_TYPE_PROFILES: begin
                     if (q_item.len_odd || (q_item.profiles == '0)) begin
                        do_drop = 1'b1;
                     end else begin
                        prof_in            = q_item.profiles;
                        do_send            = 1'b1;
                        send_code          = LINK_TYPE_STATUS;
                        res.frame_accepted = 1'b1;
                     end
                  end
                  LINK_TYPE_BAUD: begin
                     if (!q_item.baud_ok) begin
                        do_drop = 1'b1;
                     end else begin
                        res.baud_valid     = 1'b1;
                        res.baud_index     = q_item.status_byte[3:0];
                        do_send            = 1'b1;
                        send_code          = LINK_TYPE_STATUS;
                        res.frame_accepted = 1'b1;
                     end
                  end
                  default: do_drop = 1'b1;
               endcase
            end
         end
         OP_TICK: begin
            if (q_item.connect_cond) begin
               res.control_active = 1'b1;
               if (connect_due) begin
                  lct_in         = q_item.now_seconds;
                  do_send        = 1'b1;
                  send_code      = LINK_TYPE_PROFILES;
                  res.baud_valid = 1'b1;
                  res.baud_index = 4'd0;
               end
            end else if (q_item.status_cond) begin
               res.control_active = 1'b1;
               if (status_due) begin
                  do_send   = 1'b1;
                  send_code = LINK_TYPE_STATUS;
                  do_strike = q_item.contention;
                  lst_in    = q_item.now_seconds;
               end
            end
         end
         OP_SEND_FAIL: begin
            pend_in = 1'b0;
            do_drop = 1'b1;
         end
         OP_DISCONNECT: do_drop = 1'b1;
         OP_READ_ABORT: pend_in = 1'b0;
         default: res = '0;
      endcase

      if (do_strike) begin
         strike_sat = (strike_in == STRIKE_MAX) ? STRIKE_MAX : strike_in + 3'd1;
         strike_in  = strike_sat;
         if (strike_sat >= cfg.strike_limit) begin
            do_drop = 1'b1;
         end
      end
      if (do_send) begin
         last_in       = send_code;
         pend_in       = 1'b1;
         res.send_valid = 1'b1;
         res.send_type  = send_code;
      end
      if (do_drop) begin
         strike_in      = '0;
         prof_in        = '0;
         res.baud_valid = 1'b1;
         res.baud_index = 4'd0;
         res.conn_valid = 1'b1;
         res.conn_value = 1'b0;
      end
      res.profile_mask = prof_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strike_ff    <= '0;
         prof_ff      <= '0;
         last_ff      <= LINK_TYPE_NONE;
         pend_ff      <= 1'b0;
         lct_ff       <= '0;
         lst_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (pop) begin
            strike_ff <= strike_in;
            prof_ff   <= prof_in;
            last_ff   <= last_in;
            pend_ff   <= pend_in;
            lct_ff    <= lct_in;
            lst_ff    <= lst_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_ff <= res;
      end
   end

   assign rsp_port.valid          = rsp_valid_ff;
   assign rsp_port.send_valid     = rsp_ff.send_valid;
   assign rsp_port.send_type      = rsp_ff.send_type;
   assign rsp_port.baud_valid     = rsp_ff.baud_valid;
   assign rsp_port.baud_index     = rsp_ff.baud_index;
   assign rsp_port.conn_valid     = rsp_ff.conn_valid;
   assign rsp_port.conn_value     = rsp_ff.conn_value;
   assign rsp_port.frame_accepted = rsp_ff.frame_accepted;
   assign rsp_port.control_active = rsp_ff.control_active;
   assign rsp_port.profile_mask   = rsp_ff.profile_mask;

   `ALC_ASSERT_NEXT(a_frame_clears_pending, pop && (q_item.op == OP_FRAME) && !res.send_valid, !pend_ff, "frame word left a read pending")
   `ALC_ASSERT_NEXT(a_send_sets_pending, pop && res.send_valid, pend_ff && (last_ff == rsp_ff.send_type), "send not recorded")
   `ALC_ASSERT(a_send_has_type, (rsp_valid_ff && rsp_ff.send_valid) |-> (rsp_ff.send_type != LINK_TYPE_NONE), "send word without a type")
   `ALC_ASSERT(a_drop_clears_mask, (rsp_valid_ff && rsp_ff.conn_valid && !rsp_ff.conn_value) |-> (rsp_ff.profile_mask == '0), "disconnect kept profiles")

endmodule

[src/accessory_link_control_top.sv]
// accessory link control: top level
//
// events enter on req_port (valid/ready), one word per event: a response
// frame, a control tick, a send failure, an external disconnect or an
// aborted read. every event gives exactly one result word on rsp_port
// (valid/ready), in order: send request, baud change, connection update,
// frame and tick flags, and the supported profile mask after the event.
// the apb port (psel, penable, pwrite, paddr, pwdata, prdata, pready) holds
// strike limit, status check time, connect and status gaps and the
// expected protocol version at byte addresses 0, 4, 8, 12 and 16.
// an event word is classified in the same cycle it is accepted and queued
// in a two-word queue; the executing stage takes one word per cycle while
// rsp_port is not stalled and registers the result, and a new event is
// accepted every cycle while the queue has room.
// when rsp_port stalls the result register holds, the queue fills and
// req_port.ready drops once both queue words are taken.
// synchronous reset clears link state and queue and restores the register
// defaults; the block is ready as soon as reset is released.
`timescale 1ns / 1ps
module accessory_link_control_top (
   input  logic                               clock,
   input  logic                               reset,
   alc_req_if.sink                            req_port,
   alc_rsp_if.source                          rsp_port,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [alc_pkg::CsrAddrWidth-1:0]   paddr,
   input  logic [alc_pkg::CsrDataWidth-1:0]   pwdata,
   output logic [alc_pkg::CsrDataWidth-1:0]   prdata,
   output logic                               pready
);
   import alc_pkg::*;

   cfg_type  cfg;
   logic     push, not_full, pop, q_valid;
   item_type push_item, q_item;

   alc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   alc_front u_front (
      .req_port       (req_port),
      .cfg            (cfg),
      .queue_not_full (not_full),
      .push           (push),
      .push_item      (push_item)
   );

   alc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .not_full  (not_full),
      .pop       (pop),
      .out_valid (q_valid),
      .out_item  (q_item)
   );

   alc_back u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .q_valid  (q_valid),
      .q_item   (q_item),
      .pop      (pop),
      .rsp_port (rsp_port)
   );

endmodule

[bench/accessory_link_control_top_tb.sv]
// self-checking testbench of accessory_link_control_top against its own response predictor
`timescale 1ns / 1ps
module accessory_link_control_top_tb;
   import alc_pkg::*;

   localparam int unsigned WATCHDOG_LIMIT = 2000;
   localparam int unsigned LONG_HOLD      = 60;
   localparam logic [2:0]  OP_UNUSED_LO   = 3'd5;
   localparam logic [2:0]  OP_UNUSED_HI   = 3'd7;

   typedef struct packed {
      logic [2:0]  op;
      logic        rx_ok;
      logic [7:0]  rx_length;
      logic [7:0]  rx_version;
      logic [7:0]  rx_type;
      logic [31:0] rx_payload;
      logic [31:0] now_seconds;
      logic        link_up;
      logic        accessory_present;
      logic        transport_ready;
      logic [31:0] idle_seconds;
      logic        bus_contention;
   } link_event;

   logic clock = 1'b0;
   logic reset;
   logic psel, penable, pwrite, pready;
   logic [CsrAddrWidth-1:0] paddr;
   logic [CsrDataWidth-1:0] pwdata, prdata;

   alc_req_if req_bus ();
   alc_rsp_if rsp_bus ();

   accessory_link_control_top u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_bus),
      .rsp_port (rsp_bus),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   always #10 clock = ~clock;

   // link state as the block should hold it
   cfg_type     link_cfg;
   logic [2:0]  strikes;
   logic [31:0] known_profiles;
   logic [1:0]  last_request;
   logic        read_outstanding;
   logic [31:0] connect_stamp;
   logic [31:0] status_stamp;
   logic [31:0] wall_seconds;

   result_type  pending_responses[$];
   int unsigned mismatch_count = 0;
   int unsigned quiet_cycles = 0;
   bit          idle_off = 1'b0;
   bit          hold_request = 1'b0;

   task automatic flag_mismatch(input string what, input logic [31:0] got,
                                input logic [31:0] want);
      mismatch_count++;
      if (mismatch_count <= 100) begin
         $display("mismatch in %s: got %0h expected %0h", what, got, want);
      end
   endtask

   function automatic int unsigned draw_wait();
      return idle_off ? 0 : $urandom_range(0, 9);
   endfunction

   function automatic void drop_link(inout result_type res);
      strikes = '0;
      known_profiles = '0;
      res.baud_valid = 1'b1;
      res.baud_index = '0;
      res.conn_valid = 1'b1;
      res.conn_value = 1'b0;
   endfunction

   function automatic void issue_request(inout result_type res, input logic [1:0] kind);
      last_request = kind;
      read_outstanding = 1'b1;
      res.send_valid = 1'b1;
      res.send_type = kind;
   endfunction

   function automatic void add_strike(inout result_type res);
      if (strikes < STRIKE_MAX) strikes = strikes + 3'd1;
      if (strikes >= link_cfg.strike_limit) drop_link(res);
   endfunction

   function automatic logic take_frame(input link_event ev, inout result_type res);
      logic [7:0]  dlen;
      logic [31:0] pay;
      logic [7:0]  b0;
      logic [15:0] half;
      read_outstanding = 1'b0;
      if (!ev.rx_ok || ev.rx_length < 8'd2 || ev.rx_length > 8'd6 ||
          ev.rx_type != {6'd0, last_request} ||
          ev.rx_version != link_cfg.protocol_version) begin
         if (last_request == LINK_TYPE_STATUS) add_strike(res);
         else if (known_profiles == '0) drop_link(res);
         return 1'b0;
      end
      strikes = '0;
      dlen = ev.rx_length - 8'd2;
      pay = ev.rx_payload;
      if (dlen < 8'd4) pay = pay & ((32'd1 << (dlen * 8)) - 32'd1);
      b0 = pay[7:0];
      case (last_request)
         LINK_TYPE_STATUS: begin
            if (b0 == STATUS_OK) begin
               res.conn_valid = 1'b1;
               res.conn_value = 1'b1;
            end else if (b0 == STATUS_BAUD) begin
               issue_request(res, LINK_TYPE_BAUD);
            end else if (b0 == STATUS_DISCONNECT) begin
               drop_link(res);
            end else begin
               drop_link(res);
               return 1'b0;
            end
            return 1'b1;
         end
         LINK_TYPE_PROFILES: begin
            if (dlen[0]) begin
               drop_link(res);
               return 1'b0;
            end
            known_profiles = '0;
            for (int i = 0; i < dlen / 2; i++) begin
               half = pay[i*16 +: 16];
               if (half > 16'd0 && half < ProfileCount && half != LinkProfileId && half < 16'd32)
                  known_profiles[half[4:0]] = 1'b1;
            end
            if (known_profiles == '0) begin
               drop_link(res);
               return 1'b0;
            end
            issue_request(res, LINK_TYPE_STATUS);
            return 1'b1;
         end
         LINK_TYPE_BAUD: begin
            if (b0 >= BaudCount) begin
               drop_link(res);
               return 1'b0;
            end
            res.baud_valid = 1'b1;
            res.baud_index = b0[3:0];
            issue_request(res, LINK_TYPE_STATUS);
            return 1'b1;
         end
         default: begin
            drop_link(res);
            return 1'b0;
         end
      endcase
   endfunction

   function automatic logic take_tick(input link_event ev, inout result_type res);
      if (!ev.link_up && ev.accessory_present && ev.transport_ready) begin
         if (64'(ev.now_seconds) > 64'(connect_stamp) + 64'(link_cfg.connect_gap_seconds)) begin
            connect_stamp = ev.now_seconds;
            issue_request(res, LINK_TYPE_PROFILES);
            res.baud_valid = 1'b1;
            res.baud_index = '0;
         end
         return 1'b1;
      end
      if (ev.idle_seconds > {24'd0, link_cfg.status_check_seconds}) begin
         if (64'(ev.now_seconds) > 64'(status_stamp) + 64'(link_cfg.status_gap_seconds)) begin
            issue_request(res, LINK_TYPE_STATUS);
            if (ev.bus_contention) add_strike(res);
            status_stamp = ev.now_seconds;
         end
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic result_type predict_link_response(input link_event ev);
      result_type res;
      logic       flag;
      res = '0;
      case (ev.op)
         OP_FRAME: begin
            flag = take_frame(ev, res);
            res.frame_accepted = flag;
         end
         OP_TICK: begin
            flag = take_tick(ev, res);
            res.control_active = flag;
         end
         OP_SEND_FAIL: begin
            read_outstanding = 1'b0;
            drop_link(res);
         end
         OP_DISCONNECT: drop_link(res);
         OP_READ_ABORT: read_outstanding = 1'b0;
         default: ;
      endcase
      res.profile_mask = known_profiles;
      return res;
   endfunction

   function automatic link_event frame_word(input logic ok, input logic [7:0] len,
                                            input logic [7:0] ver, input logic [7:0] kind,
                                            input logic [31:0] pay);
      link_event ev;
      ev = '0;
      ev.op = OP_FRAME;
      ev.rx_ok = ok;
      ev.rx_length = len;
      ev.rx_version = ver;
      ev.rx_type = kind;
      ev.rx_payload = pay;
      return ev;
   endfunction

   function automatic link_event tick_word(input logic [31:0] now, input logic up,
                                           input logic present, input logic rdy,
                                           input logic [31:0] idle, input logic cont);
      link_event ev;
      ev = '0;
      ev.op = OP_TICK;
      ev.now_seconds = now;
      ev.link_up = up;
      ev.accessory_present = present;
      ev.transport_ready = rdy;
      ev.idle_seconds = idle;
      ev.bus_contention = cont;
      return ev;
   endfunction

   function automatic link_event other_word(input logic [2:0] op);
      link_event ev;
      ev = '0;
      ev.op = op;
      return ev;
   endfunction

   // replies that match the outstanding request most often, then ticks, junk and other events
   function automatic link_event random_link_event();
      link_event   ev;
      int unsigned pick;
      int unsigned step;
      logic [1:0]  kind;
      ev = {$urandom, $urandom, $urandom, $urandom};
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
         ev.op = OP_FRAME;
         ev.rx_ok = 1'b1;
         ev.rx_version = link_cfg.protocol_version;
         kind = last_request;
         if (kind == LINK_TYPE_NONE) kind = 2'($urandom_range(1, 3));
         ev.rx_type = {6'd0, kind};
         case (kind)
            LINK_TYPE_STATUS: begin
               ev.rx_length = 8'($urandom_range(2, 6));
               ev.rx_payload[7:0] = ($urandom_range(0, 9) < 8) ? 8'($urandom_range(0, 2))
                                                                : 8'($urandom);
            end
            LINK_TYPE_PROFILES: begin
               ev.rx_length = ($urandom_range(0, 5) == 0) ? 8'($urandom_range(2, 6))
                                                          : 8'(2 + 2 * $urandom_range(0, 2));
               ev.rx_payload[15:0] = ($urandom_range(0, 5) == 0) ? 16'($urandom)
                                                                 : 16'($urandom_range(0, 9));
               ev.rx_payload[31:16] = ($urandom_range(0, 5) == 0) ? 16'($urandom)
                                                                  : 16'($urandom_range(0, 9));
            end
            default: begin
               ev.rx_length = 8'($urandom_range(2, 6));
               ev.rx_payload[7:0] = 8'($urandom_range(0, 13));
            end
         endcase
      end else if (pick < 75) begin
         ev.op = OP_TICK;
         step = $urandom_range(0, 12);
         if (wall_seconds > 32'hFFFF_FFFF - step) wall_seconds = 32'hFFFF_FFFF;
         else wall_seconds = wall_seconds + step;
         ev.now_seconds = wall_seconds;
         ev.link_up = $urandom_range(0, 1);
         ev.accessory_present = ($urandom_range(0, 3) != 0);
         ev.transport_ready = ($urandom_range(0, 3) != 0);
         ev.idle_seconds = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 400);
         ev.bus_contention = ($urandom_range(0, 3) == 0);
      end else if (pick < 88) begin
         ev.op = OP_FRAME;
         ev.rx_ok = 1'b1;
         ev.rx_length = 8'($urandom_range(2, 6));
         ev.rx_version = link_cfg.protocol_version;
         ev.rx_type = {6'd0, last_request};
         case ($urandom_range(0, 3))
            0: ev.rx_ok = 1'b0;
            1: ev.rx_length = $urandom_range(0, 1) ? 8'($urandom_range(0, 9)) : 8'($urandom);
            2: ev.rx_version = 8'($urandom);
            default: ev.rx_type = $urandom_range(0, 1) ? 8'($urandom_range(0, 4)) : 8'($urandom);
         endcase
      end else begin
         ev.op = 3'($urandom_range(OP_SEND_FAIL, OP_UNUSED_HI));
      end
      return ev;
   endfunction

   task automatic send_link_event(input link_event ev);
      int unsigned gap;
      gap = draw_wait();
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.op                <= ev.op;
      req_bus.rx_ok             <= ev.rx_ok;
      req_bus.rx_length         <= ev.rx_length;
      req_bus.rx_version        <= ev.rx_version;
      req_bus.rx_type           <= ev.rx_type;
      req_bus.rx_payload        <= ev.rx_payload;
      req_bus.now_seconds       <= ev.now_seconds;
      req_bus.link_up           <= ev.link_up;
      req_bus.accessory_present <= ev.accessory_present;
      req_bus.transport_ready   <= ev.transport_ready;
      req_bus.idle_seconds      <= ev.idle_seconds;
      req_bus.bus_contention    <= ev.bus_contention;
      req_bus.valid             <= 1'b1;
      do @(posedge clock); while (!req_bus.ready);
      pending_responses.push_back(predict_link_response(ev));
   endtask

   task automatic wait_until_drained();
      req_bus.valid <= 1'b0;
      while (pending_responses.size() != 0) @(posedge clock);
   endtask

   task automatic write_register(input logic [2:0] idx, input logic [7:0] value);
      logic [31:0] want;
      want = (idx == REG_STRIKE_LIMIT) ? {29'd0, value[2:0]} : {24'd0, value};
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= want;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      pwrite  <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== want) flag_mismatch("register readback", prdata, want);
      case (idx)
         REG_STRIKE_LIMIT: link_cfg.strike_limit = value[2:0];
         REG_STATUS_CHECK: link_cfg.status_check_seconds = value;
         REG_CONNECT_GAP:  link_cfg.connect_gap_seconds = value;
         REG_STATUS_GAP:   link_cfg.status_gap_seconds = value;
         REG_PROTOCOL_VER: link_cfg.protocol_version = value;
         default: ;
      endcase
   endtask

   task automatic apply_settings(input logic [2:0] limit, input logic [7:0] check,
                                 input logic [7:0] cgap, input logic [7:0] sgap,
                                 input logic [7:0] ver);
      write_register(REG_STRIKE_LIMIT, {5'd0, limit});
      write_register(REG_STATUS_CHECK, check);
      write_register(REG_CONNECT_GAP, cgap);
      write_register(REG_STATUS_GAP, sgap);
      write_register(REG_PROTOCOL_VER, ver);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // replies, strikes, rejections and side events under the default settings
   task automatic test_directed();
      send_link_event(frame_word(1'b1, 8'd2, 8'd1, {6'd0, LINK_TYPE_NONE}, 32'd0));
      send_link_event(tick_word(32'd10, 1'b0, 1'b1, 1'b1, 32'd0, 1'b0));
      send_link_event(frame_word(1'b1, 8'd6, 8'd1, {6'd0, LINK_TYPE_PROFILES}, 32'h0007_0002));
      send_link_event(frame_word(1'b1, 8'd3, 8'd1, {6'd0, LINK_TYPE_STATUS}, 32'hFFFF_FF00));
      send_link_event(frame_word(1'b1, 8'd4, 8'd1, {6'd0, LINK_TYPE_STATUS}, 32'd1));
      send_link_event(frame_word(1'b1, 8'd3, 8'd1, {6'd0, LINK_TYPE_BAUD}, 32'd11));
      send_link_event(frame_word(1'b1, 8'd2, 8'd1, {6'd0, LINK_TYPE_STATUS}, 32'hFFFF_FFFF));
      send_link_event(frame_word(1'b1, 8'd3, 8'd1, {6'd0, LINK_TYPE_STATUS}, 32'd2));
      send_link_event(tick_word(32'd20, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b1));
      send_link_event(frame_word(1'b0, 8'd3, 8'd1, {6'd0, LINK_TYPE_STATUS}, 32'd0));
      send_link_event(frame_word(1'b1, 8'd7, 8'd1, {6'd0, LINK_TYPE_STATUS}, 32'd0));
      send_link_event(frame_word(1'b1, 8'd1, 8'd1, {6'd0, LINK_TYPE_STATUS}, 32'd0));
      send_link_event(frame_word(1'b1, 8'd3, 8'hFF, {6'd0, LINK_TYPE_STATUS}, 32'd0));
      send_link_event(frame_word(1'b1, 8'd3, 8'd1, {6'd0, LINK_TYPE_STATUS}, 32'hFF));
      send_link_event(tick_word(32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0, 32'd0, 1'b0));
      send_link_event(tick_word(32'd11, 1'b0, 1'b1, 1'b1, 32'd0, 1'b0));
      send_link_event(tick_word(32'd30, 1'b0, 1'b1, 1'b1, 32'd0, 1'b0));
      send_link_event(frame_word(1'b1, 8'd5, 8'd1, {6'd0, LINK_TYPE_PROFILES}, 32'h0000_0002));
      send_link_event(frame_word(1'b1, 8'd6, 8'd1, {6'd0, LINK_TYPE_PROFILES}, 32'hFFFF_0001));
      send_link_event(frame_word(1'b1, 8'd6, 8'd1, {6'd0, LINK_TYPE_PROFILES}, 32'h0008_0003));
      send_link_event(frame_word(1'b1, 8'd3, 8'd1, {6'd0, LINK_TYPE_STATUS}, 32'd1));
      send_link_event(frame_word(1'b1, 8'd3, 8'd1, {6'd0, LINK_TYPE_BAUD}, 32'd12));
      send_link_event(frame_word(1'b1, 8'd3, 8'd1, {6'd0, LINK_TYPE_STATUS}, 32'd0));
      send_link_event(other_word(OP_SEND_FAIL));
      send_link_event(other_word(OP_DISCONNECT));
      send_link_event(other_word(OP_READ_ABORT));
      send_link_event(other_word(OP_UNUSED_LO));
      send_link_event(other_word(OP_UNUSED_HI));
      wait_until_drained();
   endtask

   task automatic test_settings_sweep();
      for (int s = 0; s < 5; s++) begin
         case (s)
            0: apply_settings(3'd1, 8'd0, 8'd0, 8'd0, 8'd0);
            1: apply_settings(3'd7, 8'd255, 8'd255, 8'd255, 8'd255);
            2: apply_settings(3'd2, 8'd20, 8'd3, 8'd8, 8'h5A);
            3: apply_settings(3'($urandom_range(1, 7)), 8'($urandom_range(0, 60)),
                              8'($urandom_range(0, 20)), 8'($urandom_range(0, 30)),
                              8'($urandom));
            default: apply_settings(3'd3, 8'd5, 8'd1, 8'd5, 8'd1);
         endcase
         for (int n = 0; n < 200; n++) begin
            if (n % 50 == 0) idle_off = ($urandom_range(0, 3) == 0);
            send_link_event(random_link_event());
         end
         idle_off = 1'b0;
         wait_until_drained();
      end
   endtask

   // receiver holds off while words keep coming, so the queue fills and input stalls
   task automatic test_backpressure();
      idle_off = 1'b1;
      hold_request = 1'b1;
      repeat (40) send_link_event(random_link_event());
      idle_off = 1'b0;
      wait_until_drained();
   endtask

   // rate limits close to the top of the seconds counter
   task automatic test_clock_wrap();
      apply_settings(3'd4, 8'd2, 8'd255, 8'd200, 8'd1);
      wall_seconds = 32'hFFFF_FF80;
      repeat (60) send_link_event(random_link_event());
      wait_until_drained();
   endtask

   task automatic check_response();
      result_type got;
      result_type want;
      got = {rsp_bus.send_valid, rsp_bus.send_type, rsp_bus.baud_valid, rsp_bus.baud_index,
             rsp_bus.conn_valid, rsp_bus.conn_value, rsp_bus.frame_accepted,
             rsp_bus.control_active, rsp_bus.profile_mask};
      if (pending_responses.size() == 0) begin
         flag_mismatch("word with nothing expected", got.profile_mask, '0);
         return;
      end
      want = pending_responses.pop_front();
      if (got.send_valid !== want.send_valid)
         flag_mismatch("send_valid", got.send_valid, want.send_valid);
      if (got.send_type !== want.send_type)
         flag_mismatch("send_type", got.send_type, want.send_type);
      if (got.baud_valid !== want.baud_valid)
         flag_mismatch("baud_valid", got.baud_valid, want.baud_valid);
      if (got.baud_index !== want.baud_index)
         flag_mismatch("baud_index", got.baud_index, want.baud_index);
      if (got.conn_valid !== want.conn_valid)
         flag_mismatch("conn_valid", got.conn_valid, want.conn_valid);
      if (got.conn_value !== want.conn_value)
         flag_mismatch("conn_value", got.conn_value, want.conn_value);
      if (got.frame_accepted !== want.frame_accepted)
         flag_mismatch("frame_accepted", got.frame_accepted, want.frame_accepted);
      if (got.control_active !== want.control_active)
         flag_mismatch("control_active", got.control_active, want.control_active);
      if (got.profile_mask !== want.profile_mask)
         flag_mismatch("profile_mask", got.profile_mask, want.profile_mask);
   endtask

   initial begin
      int unsigned stall;
      rsp_bus.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            stall = LONG_HOLD;
         end else begin
            stall = draw_wait();
         end
         if (stall != 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
         check_response();
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (psel && penable)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("accessory_link_control_top_tb NOT OK");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset   <= 1'b1;
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= '0;
      pwdata  <= '0;
      req_bus.valid             <= 1'b0;
      req_bus.op                <= '0;
      req_bus.rx_ok             <= 1'b0;
      req_bus.rx_length         <= '0;
      req_bus.rx_version        <= '0;
      req_bus.rx_type           <= '0;
      req_bus.rx_payload        <= '0;
      req_bus.now_seconds       <= '0;
      req_bus.link_up           <= 1'b0;
      req_bus.accessory_present <= 1'b0;
      req_bus.transport_ready   <= 1'b0;
      req_bus.idle_seconds      <= '0;
      req_bus.bus_contention    <= 1'b0;
      link_cfg         = CFG_RESET;
      strikes          = '0;
      known_profiles   = '0;
      last_request     = LINK_TYPE_NONE;
      read_outstanding = 1'b0;
      connect_stamp    = '0;
      status_stamp     = '0;
      wall_seconds     = 32'd40;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_settings_sweep();
      test_backpressure();
      test_clock_wrap();
      repeat (4) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("accessory_link_control_top_tb OK");
      end else begin
         $display("accessory_link_control_top_tb NOT OK");
      end
      $finish;
   end

endmodule
